// ----- hdl/rpcd_pkg.sv -----
// shared types, constants and timing table for the remote pulse code decoder
package rpcd_pkg;

  localparam int DefMaxPulses   = 512;
  localparam int DefMaxCodeBits = 32;

  localparam int DurW       = 17;
  localparam int MagW       = 16;
  localparam int TolW       = 7;
  localparam int MinBitsW   = 6;
  localparam int MinPulsesW = 10;
  localparam int ProtoW     = 4;
  localparam int BitsW      = 6;
  localparam int CodeW      = 32;
  localparam int TargetW    = 15;
  localparam int TpW        = TargetW + TolW;
  localparam int DiffW      = MagW + 7;

  localparam int ProtoTotal = 12;
  localparam logic [ProtoW-1:0] LastProto = ProtoW'(ProtoTotal - 1);

  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  localparam logic [1:0] RegTolerance = 2'd0;
  localparam logic [1:0] RegMinBits   = 2'd1;
  localparam logic [1:0] RegMinPulses = 2'd2;

  localparam logic [TolW-1:0]       RstTolerance = TolW'(60);
  localparam logic [MinBitsW-1:0]   RstMinBits   = MinBitsW'(8);
  localparam logic [MinPulsesW-1:0] RstMinPulses = MinPulsesW'(20);

  typedef struct packed {
    logic [TargetW-1:0] sync_hi;
    logic [TargetW-1:0] sync_lo;
    logic [TargetW-1:0] zero_hi;
    logic [TargetW-1:0] zero_lo;
    logic [TargetW-1:0] one_hi;
    logic [TargetW-1:0] one_lo;
  } timing_t;

  typedef struct packed {
    logic load;
    logic init_proto;
    logic next_proto;
    logic set_params;
    logic rd_hi;
    logic rd_lo;
    logic latch_hi;
    logic start_bits;
    logic shift_bit;
    logic next_sync;
    logic emit;
    logic emit_found;
  } cmd_t;

  typedef struct packed {
    logic short_buf;
    logic sync_ok;
    logic zero_ok;
    logic one_ok;
    logic bit_mode;
    logic loop_ok;
    logic sync_more;
    logic last_proto;
    logic enough;
    logic out_free;
  } sts_t;

  function automatic timing_t mk_timing(int base, int sh, int sl, int zh, int zl,
                                        int oh, int ol);
    timing_t t;
    t.sync_hi = TargetW'(base * sh);
    t.sync_lo = TargetW'(base * sl);
    t.zero_hi = TargetW'(base * zh);
    t.zero_lo = TargetW'(base * zl);
    t.one_hi  = TargetW'(base * oh);
    t.one_lo  = TargetW'(base * ol);
    return t;
  endfunction

  function automatic timing_t proto_timing(logic [ProtoW-1:0] idx);
    timing_t t;
    case (idx)
      4'd0:    t = mk_timing(350,   1,  31,  1,  3,  3,  1);
      4'd1:    t = mk_timing(650,   1,  10,  1,  2,  2,  1);
      4'd2:    t = mk_timing(100,  30,  71,  4, 11,  9,  6);
      4'd3:    t = mk_timing(380,   1,   6,  1,  3,  3,  1);
      4'd4:    t = mk_timing(500,   6,  14,  1,  2,  2,  1);
      4'd5:    t = mk_timing(450,  23,   1,  1,  2,  2,  1);
      4'd6:    t = mk_timing(150,   2,  62,  1,  6,  6,  1);
      4'd7:    t = mk_timing(200,   3, 130,  7, 16,  3, 16);
      4'd8:    t = mk_timing(200, 130,   7, 16,  7, 16,  3);
      4'd9:    t = mk_timing(365,  18,   1,  3,  1,  1,  3);
      4'd10:   t = mk_timing(270,  36,   1,  1,  2,  2,  1);
      4'd11:   t = mk_timing(320,  36,   1,  1,  2,  2,  1);
      default: t = '0;
    endcase
    return t;
  endfunction

  // 100*|mag-target| <= target*tol is the same test as |mag-target| <= floor(target*tol/100)
  function automatic logic near_target(logic [MagW-1:0] mag, logic [TargetW-1:0] target,
                                       logic [TpW-1:0] tp);
    logic [MagW-1:0]  d;
    logic [DiffW-1:0] d100;
    d    = (mag >= MagW'(target)) ? (mag - MagW'(target)) : (MagW'(target) - mag);
    d100 = (DiffW'(d) << 6) + (DiffW'(d) << 5) + (DiffW'(d) << 2);
    return d100 <= DiffW'(tp);
  endfunction

endpackage

// ----- hdl/rpcd_regs.sv -----
// configuration registers behind the apb port
module rpcd_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rpcd_pkg::ApbAddrW-1:0]     paddr,
  input  logic [rpcd_pkg::ApbDataW-1:0]     pwdata,
  output logic [rpcd_pkg::ApbDataW-1:0]     prdata,
  output logic                              pready,
  output logic [rpcd_pkg::TolW-1:0]         tolerance_o,
  output logic [rpcd_pkg::MinBitsW-1:0]     min_bits_o,
  output logic [rpcd_pkg::MinPulsesW-1:0]   min_pulses_o
);
  import rpcd_pkg::*;

  logic [TolW-1:0]       tolerance_q;
  logic [MinBitsW-1:0]   min_bits_q;
  logic [MinPulsesW-1:0] min_pulses_q;
  logic [1:0]            reg_idx;
  logic                  wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q  <= RstTolerance;
      min_bits_q   <= RstMinBits;
      min_pulses_q <= RstMinPulses;
    end else if (wr_en) begin
      case (reg_idx)
        RegTolerance: tolerance_q  <= pwdata[TolW-1:0];
        RegMinBits:   min_bits_q   <= pwdata[MinBitsW-1:0];
        RegMinPulses: min_pulses_q <= pwdata[MinPulsesW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegTolerance: prdata = ApbDataW'(tolerance_q);
      RegMinBits:   prdata = ApbDataW'(min_bits_q);
      RegMinPulses: prdata = ApbDataW'(min_pulses_q);
      default:      prdata = '0;
    endcase
  end

  assign tolerance_o  = tolerance_q;
  assign min_bits_o   = min_bits_q;
  assign min_pulses_o = min_pulses_q;

endmodule

// ----- hdl/rpcd_ctrl.sv -----
// scan sequencer: loads the buffer, walks protocols, sync positions and bit pairs
module rpcd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_tvalid_i,
  input  logic                 in_tlast_i,
  output logic                 in_tready_o,
  input  rpcd_pkg::sts_t       sts_i,
  output rpcd_pkg::cmd_t       cmd_o
);
  import rpcd_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_PSET  = 4'd2;
  localparam logic [3:0] S_RDH   = 4'd3;
  localparam logic [3:0] S_CKH   = 4'd4;
  localparam logic [3:0] S_CKL   = 4'd5;
  localparam logic [3:0] S_CHK   = 4'd6;
  localparam logic [3:0] S_NXT   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       found_q, found_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    found_d     = found_q;
    cmd_o       = '0;
    in_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_tready_o = 1'b1;
        if (in_tvalid_i) begin
          cmd_o.load = 1'b1;
          if (in_tlast_i) state_d = S_START;
        end
      end
      S_START: begin
        if (sts_i.short_buf) begin
          found_d = 1'b0;
          state_d = S_EMIT;
        end else begin
          cmd_o.init_proto = 1'b1;
          state_d          = S_PSET;
        end
      end
      S_PSET: begin
        cmd_o.set_params = 1'b1;
        state_d          = S_RDH;
      end
      S_RDH: begin
        cmd_o.rd_hi = 1'b1;
        state_d     = S_CKH;
      end
      S_CKH: begin
        cmd_o.latch_hi = 1'b1;
        cmd_o.rd_lo    = 1'b1;
        state_d        = S_CKL;
      end
      S_CKL: begin
        if (!sts_i.bit_mode) begin
          if (sts_i.sync_ok) begin
            cmd_o.start_bits = 1'b1;
            state_d          = S_CHK;
          end else begin
            state_d = S_NXT;
          end
        end else if (sts_i.zero_ok || sts_i.one_ok) begin
          cmd_o.shift_bit = 1'b1;
          state_d         = S_CHK;
        end else begin
          state_d = S_NXT;
        end
      end
      S_CHK: begin
        if (sts_i.loop_ok) begin
          state_d = S_RDH;
        end else if (sts_i.enough) begin
          found_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          state_d = S_NXT;
        end
      end
      S_NXT: begin
        if (sts_i.sync_more) begin
          cmd_o.next_sync = 1'b1;
          state_d         = S_RDH;
        end else if (sts_i.last_proto) begin
          found_d = 1'b0;
          state_d = S_EMIT;
        end else begin
          cmd_o.next_proto = 1'b1;
          state_d          = S_PSET;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_found = found_q;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/rpcd_dp.sv -----
// datapath: pulse store, timing compares, scan counters and result register
module rpcd_dp #(
  parameter int MAX_PULSES    = rpcd_pkg::DefMaxPulses,
  parameter int MAX_CODE_BITS = rpcd_pkg::DefMaxCodeBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rpcd_pkg::cmd_t                    cmd_i,
  output rpcd_pkg::sts_t                    sts_o,
  input  logic [rpcd_pkg::DurW-1:0]         in_data_i,
  input  logic [rpcd_pkg::TolW-1:0]         tolerance_i,
  input  logic [rpcd_pkg::MinBitsW-1:0]     min_bits_i,
  input  logic [rpcd_pkg::MinPulsesW-1:0]   min_pulses_i,
  input  logic                              out_tready_i,
  output logic                              out_tvalid_o,
  output logic                              out_found_o,
  output logic [rpcd_pkg::ProtoW-1:0]       out_proto_o,
  output logic [rpcd_pkg::BitsW-1:0]        out_bits_o,
  output logic [rpcd_pkg::CodeW-1:0]        out_code_o
);
  import rpcd_pkg::*;

  localparam int AW   = $clog2(MAX_PULSES);
  localparam int CW   = $clog2(MAX_PULSES + 1);
  localparam int PW   = CW + 1;
  localparam int CmpW = (CW > MinPulsesW) ? CW : MinPulsesW;
  localparam logic [BitsW-1:0] MaxBits = BitsW'(MAX_CODE_BITS);
  localparam logic [CW-1:0]    MaxCnt  = CW'(MAX_PULSES);

  logic [MagW-1:0] mem [MAX_PULSES];
  logic [MagW-1:0] rd_data_q;
  logic [AW-1:0]   rd_addr;

  logic [CW-1:0]            count_q;
  logic [ProtoW-1:0]        proto_q;
  logic [CW-1:0]            sync_q;
  logic [PW-1:0]            pos_q;
  logic                     bit_mode_q;
  logic [BitsW-1:0]         bits_q;
  logic [MAX_CODE_BITS-1:0] shift_q;
  logic                     hi_sync_q, hi_zero_q, hi_one_q;
  timing_t                  tgt_q;
  logic [TpW-1:0]           tp_sh_q, tp_sl_q, tp_zh_q, tp_zl_q, tp_oh_q, tp_ol_q;
  timing_t                  tgt_new;

  logic                     out_valid_q;
  logic                     out_found_q;
  logic [ProtoW-1:0]        out_proto_q;
  logic [BitsW-1:0]         out_bits_q;
  logic [CodeW-1:0]         out_code_q;

  logic [DurW-1:0] neg_mag;
  logic [MagW-1:0] in_mag;
  logic            lo_sync, lo_zero, lo_one;

  // magnitude with saturation of the most negative code
  assign neg_mag = (~in_data_i) + DurW'(1);
  always_comb begin
    if (!in_data_i[DurW-1]) in_mag = in_data_i[MagW-1:0];
    else if (neg_mag[DurW-1]) in_mag = '1;
    else in_mag = neg_mag[MagW-1:0];
  end

  assign rd_addr = cmd_i.rd_lo ? AW'(pos_q + PW'(1)) : AW'(pos_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < MaxCnt)) mem[count_q[AW-1:0]] <= in_mag;
    if (cmd_i.rd_hi || cmd_i.rd_lo) rd_data_q <= mem[rd_addr];
  end

  assign tgt_new = proto_timing(proto_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_params) begin
      tgt_q   <= tgt_new;
      tp_sh_q <= TpW'(tgt_new.sync_hi) * TpW'(tolerance_i);
      tp_sl_q <= TpW'(tgt_new.sync_lo) * TpW'(tolerance_i);
      tp_zh_q <= TpW'(tgt_new.zero_hi) * TpW'(tolerance_i);
      tp_zl_q <= TpW'(tgt_new.zero_lo) * TpW'(tolerance_i);
      tp_oh_q <= TpW'(tgt_new.one_hi) * TpW'(tolerance_i);
      tp_ol_q <= TpW'(tgt_new.one_lo) * TpW'(tolerance_i);
    end
    if (cmd_i.latch_hi) begin
      hi_sync_q <= near_target(rd_data_q, tgt_q.sync_hi, tp_sh_q);
      hi_zero_q <= near_target(rd_data_q, tgt_q.zero_hi, tp_zh_q);
      hi_one_q  <= near_target(rd_data_q, tgt_q.one_hi, tp_oh_q);
    end
    if (cmd_i.start_bits) begin
      shift_q <= '0;
    end else if (cmd_i.shift_bit) begin
      shift_q <= {shift_q[MAX_CODE_BITS-2:0], ~(hi_zero_q & lo_zero)};
    end
  end

  assign lo_sync = near_target(rd_data_q, tgt_q.sync_lo, tp_sl_q);
  assign lo_zero = near_target(rd_data_q, tgt_q.zero_lo, tp_zl_q);
  assign lo_one  = near_target(rd_data_q, tgt_q.one_lo, tp_ol_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      proto_q    <= '0;
      sync_q     <= '0;
      pos_q      <= '0;
      bit_mode_q <= 1'b0;
      bits_q     <= '0;
    end else begin
      if (cmd_i.emit) begin
        count_q <= '0;
      end else if (cmd_i.load && (count_q < MaxCnt)) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.init_proto) proto_q <= '0;
      else if (cmd_i.next_proto) proto_q <= proto_q + ProtoW'(1);
      if (cmd_i.set_params) begin
        sync_q     <= '0;
        pos_q      <= '0;
        bit_mode_q <= 1'b0;
      end else if (cmd_i.next_sync) begin
        sync_q     <= sync_q + CW'(1);
        pos_q      <= PW'(sync_q) + PW'(1);
        bit_mode_q <= 1'b0;
      end else if (cmd_i.start_bits) begin
        pos_q      <= PW'(sync_q) + PW'(2);
        bit_mode_q <= 1'b1;
        bits_q     <= '0;
      end else if (cmd_i.shift_bit) begin
        pos_q  <= pos_q + PW'(2);
        bits_q <= bits_q + BitsW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_found_q <= cmd_i.emit_found;
      out_proto_q <= cmd_i.emit_found ? proto_q : '0;
      out_bits_q  <= cmd_i.emit_found ? bits_q : '0;
      out_code_q  <= cmd_i.emit_found ? CodeW'(shift_q) : '0;
    end
  end

  assign sts_o.short_buf  = (CmpW'(count_q) < CmpW'(min_pulses_i)) || (count_q < CW'(2));
  assign sts_o.sync_ok    = hi_sync_q & lo_sync;
  assign sts_o.zero_ok    = hi_zero_q & lo_zero;
  assign sts_o.one_ok     = hi_one_q & lo_one;
  assign sts_o.bit_mode   = bit_mode_q;
  assign sts_o.loop_ok    = ((pos_q + PW'(1)) < PW'(count_q)) && (bits_q < MaxBits);
  assign sts_o.sync_more  = (PW'(sync_q) + PW'(2)) < PW'(count_q);
  assign sts_o.last_proto = (proto_q == LastProto);
  assign sts_o.enough     = (bits_q >= min_bits_i);
  assign sts_o.out_free   = ~out_valid_q | out_tready_i;

  assign out_tvalid_o = out_valid_q;
  assign out_found_o  = out_found_q;
  assign out_proto_o  = out_proto_q;
  assign out_bits_o   = out_bits_q;
  assign out_code_o   = out_code_q;

  a_read_in_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_hi |-> ((pos_q + PW'(1)) < PW'(count_q)))
    else $error("pair read beyond buffered durations");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (count_q == '0))
    else $error("buffer count not cleared after result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("buffer count above capacity");

  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bits_q <= MaxBits)
    else $error("decoded bit count above code width");

endmodule

// ----- hdl/remote_pulse_code_decoder.sv -----
// top level of the remote pulse code decoder
//
// channel   dir  handshake                 contents
// s_axis    in   tvalid/tready, tlast      pulse_duration in tdata, last_pulse as tlast
// m_axis    out  tvalid/tready             code_found in tuser, result fields in tdata
// apb       in   psel/penable/pwrite       tolerance_percent, min_bits, min_pulses
//
// durations are accepted while the sequencer is idle; the last one starts a scan and the port stays low
// until the result is loaded into the output register.
// the scan reads the single-port pulse store: per pulse pair it reads the high duration,
// then the low one while latching the high compares, then checks the loop; 12 protocols.
// reset clears counters, state and the output valid; the pulse store is not cleared.
// a result waiting on m_axis does not block loading of the next buffer.
module remote_pulse_code_decoder #(
  parameter int MAX_PULSES    = rpcd_pkg::DefMaxPulses,
  parameter int MAX_CODE_BITS = rpcd_pkg::DefMaxCodeBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // [16:0] pulse_duration
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [3:0] protocol_number, [9:4] bit_total, [41:10] code_value
  output logic [47:0]                     m_axis_tdata,
  output logic                            m_axis_tuser,  // [0] code_found
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rpcd_pkg::ApbAddrW-1:0]   paddr,
  input  logic [rpcd_pkg::ApbDataW-1:0]   pwdata,
  output logic [rpcd_pkg::ApbDataW-1:0]   prdata,
  output logic                            pready
);
  import rpcd_pkg::*;

  cmd_t                  cmd;
  sts_t                  sts;
  logic [TolW-1:0]       tolerance;
  logic [MinBitsW-1:0]   min_bits;
  logic [MinPulsesW-1:0] min_pulses;
  logic [ProtoW-1:0]     out_proto;
  logic [BitsW-1:0]      out_bits;
  logic [CodeW-1:0]      out_code;

  rpcd_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .tolerance_o  (tolerance),
    .min_bits_o   (min_bits),
    .min_pulses_o (min_pulses)
  );

  rpcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tlast_i  (s_axis_tlast),
    .in_tready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rpcd_dp #(
    .MAX_PULSES    (MAX_PULSES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_data_i    (s_axis_tdata[DurW-1:0]),
    .tolerance_i  (tolerance),
    .min_bits_i   (min_bits),
    .min_pulses_i (min_pulses),
    .out_tready_i (m_axis_tready),
    .out_tvalid_o (m_axis_tvalid),
    .out_found_o  (m_axis_tuser),
    .out_proto_o  (out_proto),
    .out_bits_o   (out_bits),
    .out_code_o   (out_code)
  );

  assign m_axis_tdata = {6'd0, out_code, out_bits, out_proto};

endmodule

// ----- sim/tb_remote_pulse_code_decoder.sv -----
`timescale 1ns / 1ps
// testbench for the remote pulse code decoder: directed and random pulse buffers
module tb_remote_pulse_code_decoder;
  import rpcd_pkg::*;

  localparam int HalfPeriod  = 6;
  localparam int BufDepth    = 512;
  localparam int CodeBitsMax = 32;
  localparam int HoldCycles  = 3000;
  localparam int IdleLimit   = 4000000;
  localparam int DrainCycles = 40;
  localparam int OverflowLen = 530;
  localparam int BaseCol     = 0;
  localparam int SyncCol     = 1;
  localparam int ZeroCol     = 3;
  localparam int OneCol      = 5;

  typedef struct packed {
    logic [DurW-1:0] dur;
    logic            last;
  } pulse_word_t;

  typedef struct packed {
    logic              found;
    logic [ProtoW-1:0] proto;
    logic [BitsW-1:0]  nbits;
    logic [CodeW-1:0]  code;
  } decode_t;

  // base, sync hi/lo, zero hi/lo, one hi/lo
  int timing_tab [ProtoTotal][7] = '{
    '{350,   1,  31,  1,  3,  3,  1},
    '{650,   1,  10,  1,  2,  2,  1},
    '{100,  30,  71,  4, 11,  9,  6},
    '{380,   1,   6,  1,  3,  3,  1},
    '{500,   6,  14,  1,  2,  2,  1},
    '{450,  23,   1,  1,  2,  2,  1},
    '{150,   2,  62,  1,  6,  6,  1},
    '{200,   3, 130,  7, 16,  3, 16},
    '{200, 130,   7, 16,  7, 16,  3},
    '{365,  18,   1,  3,  1,  1,  3},
    '{270,  36,   1,  1,  2,  2,  1},
    '{320,  36,   1,  1,  2,  2,  1}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;  // [16:0] pulse_duration
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [3:0] protocol_number, [9:4] bit_total, [41:10] code_value
  logic [47:0]         m_axis_tdata;
  logic                m_axis_tuser;        // [0] code_found
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  remote_pulse_code_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #HalfPeriod clk_i = ~clk_i;

  pulse_word_t     pulse_q[$];
  decode_t         result_q[$];
  logic [DurW-1:0] dur_store [BufDepth];
  int              dur_count      = 0;
  int              tol_pct        = 60;
  int              min_bits_cfg   = 8;
  int              min_pulses_cfg = 20;
  int              words_in       = 0;
  int              words_seen     = 0;
  int              send_gap       = 0;
  int              recv_stall     = 0;
  int              idle_cycles    = 0;
  int              err_cnt        = 0;
  bit              idle_on        = 1'b1;
  bit              hold_off_req   = 1'b0;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    err_cnt++;
  endtask

  function automatic int dur_magnitude(logic [DurW-1:0] raw);
    int m;
    m = raw[DurW-1] ? (32'h20000 - int'(raw)) : int'(raw);
    return (m > 65535) ? 65535 : m;
  endfunction

  function automatic bit in_window(logic [DurW-1:0] raw, int target);
    int mag;
    int tol;
    mag = dur_magnitude(raw);
    tol = target * tol_pct / 100;
    return (mag + tol >= target) && (mag <= target + tol);
  endfunction

  function automatic bit pair_matches(int pos, int p, int col);
    return in_window(dur_store[pos], timing_tab[p][BaseCol] * timing_tab[p][col]) &&
           in_window(dur_store[pos+1], timing_tab[p][BaseCol] * timing_tab[p][col+1]);
  endfunction

  function automatic decode_t decode_buffer();
    decode_t          r;
    int               n;
    int               bits;
    int               b;
    bit               miss;
    logic [CodeW-1:0] shreg;
    r = '0;
    n = dur_count;
    if (n < min_pulses_cfg || n < 2) return r;
    for (int p = 0; p < ProtoTotal; p++) begin
      for (int s = 0; s + 1 < n; s++) begin
        if (!pair_matches(s, p, SyncCol)) continue;
        shreg = '0;
        bits  = 0;
        b     = s + 2;
        miss  = 1'b0;
        while (b + 1 < n && bits < CodeBitsMax) begin
          if (pair_matches(b, p, ZeroCol)) shreg = {shreg[CodeW-2:0], 1'b0};
          else if (pair_matches(b, p, OneCol)) shreg = {shreg[CodeW-2:0], 1'b1};
          else begin
            miss = 1'b1;
            break;
          end
          bits++;
          b += 2;
        end
        if (!miss && bits >= min_bits_cfg) begin
          r.found = 1'b1;
          r.proto = ProtoW'(p);
          r.nbits = BitsW'(bits);
          r.code  = shreg;
          return r;
        end
      end
    end
    return r;
  endfunction

  function automatic void store_pulse(pulse_word_t w);
    if (dur_count < BufDepth) begin
      dur_store[dur_count] = w.dur;
      dur_count++;
    end
    if (w.last) begin
      result_q.push_back(decode_buffer());
      dur_count = 0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99, 0);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // result check first, then the accepted input word
  always @(posedge clk_i) begin
    decode_t want;
    if (rst_ni) begin
      idle_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        if (result_q.size() == 0) begin
          report_mismatch("result with nothing expected", m_axis_tdata, 0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tuser !== want.found)
            report_mismatch("code_found", m_axis_tuser, want.found);
          if (m_axis_tdata[3:0] !== want.proto)
            report_mismatch("protocol_number", m_axis_tdata[3:0], want.proto);
          if (m_axis_tdata[9:4] !== want.nbits)
            report_mismatch("bit_total", m_axis_tdata[9:4], want.nbits);
          if (m_axis_tdata[41:10] !== want.code)
            report_mismatch("code_value", m_axis_tdata[41:10], want.code);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        idle_cycles = 0;
        store_pulse(pulse_q.pop_front());
        words_in++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb_remote_pulse_code_decoder NOT OK");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (words_seen != words_in) begin
        words_seen = words_in;
        send_gap   = pick_gap();
      end
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pulse_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, pulse_q[0].dur};
        s_axis_tlast  <= pulse_q[0].last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        recv_stall   = HoldCycles;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        recv_stall = pick_gap();
        m_axis_tready <= (recv_stall == 0);
      end
    end
  end

  task automatic apb_cycle(logic [1:0] idx, bit wr, int wdata, output logic [ApbDataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ApbAddrW'({idx, 2'b00});
    pwdata  <= ApbDataW'(wdata);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_check(logic [1:0] idx, int val);
    logic [ApbDataW-1:0] rd;
    apb_cycle(idx, 1'b0, 0, rd);
    if (rd !== ApbDataW'(val)) report_mismatch("register readback", rd, val);
  endtask

  task automatic reg_write(logic [1:0] idx, int val);
    logic [ApbDataW-1:0] rd;
    apb_cycle(idx, 1'b1, val, rd);
    case (idx)
      RegTolerance: tol_pct        = val;
      RegMinBits:   min_bits_cfg   = val;
      RegMinPulses: min_pulses_cfg = val;
      default: ;
    endcase
    reg_check(idx, val);
  endtask

  function automatic void push_dur(int value, bit last);
    pulse_word_t w;
    w.dur  = value[DurW-1:0];
    w.last = last;
    pulse_q.push_back(w);
  endfunction

  function automatic int noise_dur();
    if ($urandom_range(1, 0)) return $urandom_range(32'h1FFFF, 0);
    return $urandom_range(1, 0) ? $urandom_range(30000, 0) : -$urandom_range(30000, 0);
  endfunction

  // high levels positive, low levels negative, sign flipped now and then
  function automatic int level(int mag, bit low);
    bit neg;
    neg = low ^ ($urandom_range(9, 0) == 0);
    return neg ? -mag : mag;
  endfunction

  // a duration inside the window, on its edges, or just outside
  function automatic int around(int target, bit edgy);
    int tol;
    int lo;
    int hi;
    int r;
    tol = target * tol_pct / 100;
    lo  = (target > tol) ? target - tol : 0;
    hi  = (target + tol > 65535) ? 65535 : target + tol;
    r   = edgy ? $urandom_range(99, 0) : 99;
    if (r < 6) return hi;
    if (r < 12) return lo;
    if (r < 14) return (hi < 65535) ? hi + 1 : lo;
    if (r < 16) return (lo > 0) ? lo - 1 : hi;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int queue_frame(bit close);
    int p;
    int base;
    int nb;
    int pre;
    int post;
    int col;
    bit edgy;
    p    = $urandom_range(ProtoTotal - 1, 0);
    base = timing_tab[p][BaseCol];
    nb   = ($urandom_range(9, 0) == 0) ? $urandom_range(36, 33) : $urandom_range(CodeBitsMax, 1);
    pre  = ($urandom_range(3, 0) == 0) ? $urandom_range(3, 1) : 0;
    post = ($urandom_range(4, 0) == 0) ? $urandom_range(2, 1) : 0;
    edgy = $urandom_range(1, 0);
    for (int k = 0; k < pre; k++) push_dur(noise_dur(), 1'b0);
    push_dur(level(around(base * timing_tab[p][SyncCol], edgy), 1'b0), 1'b0);
    push_dur(level(around(base * timing_tab[p][SyncCol+1], edgy), 1'b1), 1'b0);
    for (int b = 0; b < nb; b++) begin
      col = $urandom_range(1, 0) ? OneCol : ZeroCol;
      push_dur(level(around(base * timing_tab[p][col], edgy), 1'b0), 1'b0);
      push_dur(level(around(base * timing_tab[p][col+1], edgy), 1'b1),
               close && post == 0 && b == nb - 1);
    end
    for (int k = 0; k < post; k++) push_dur(noise_dur(), close && k == post - 1);
    return pre + 2 + 2 * nb + post;
  endfunction

  function automatic int queue_noise(int len);
    for (int k = 0; k < len; k++) push_dur(noise_dur(), k == len - 1);
    return len;
  endfunction

  function automatic int queue_buffer();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return queue_frame(1'b1);
    if (r < 90) return queue_noise($urandom_range(40, 4));
    return queue_noise($urandom_range(3, 1));
  endfunction

  function automatic int queue_noise_open(int len);
    for (int k = 0; k < len; k++) push_dur(noise_dur(), 1'b0);
    return len;
  endfunction

  // more durations than the store holds, with a frame somewhere in the middle
  function automatic int queue_overflow();
    int n;
    n = queue_noise_open($urandom_range(300, 100));
    n += queue_frame(1'b0);
    while (n < OverflowLen - 1) begin
      push_dur(noise_dur(), 1'b0);
      n++;
    end
    push_dur(noise_dur(), 1'b1);
    return n + 1;
  endfunction

  task automatic wait_drained();
    while (pulse_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(int tol, int mb, int mp, bit idle, int budget, bit pressure,
                           bit overflow);
    int queued;
    reg_write(RegTolerance, tol);
    reg_write(RegMinBits, mb);
    reg_write(RegMinPulses, mp);
    idle_on = idle;
    queued  = 0;
    if (overflow) queued += queue_overflow();
    while (queued < budget) queued += queue_buffer();
    if (pressure) hold_off_req = 1'b1;
    wait_drained();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    reg_check(RegTolerance, 60);
    reg_check(RegMinBits, 8);
    reg_check(RegMinPulses, 20);

    reg_write(RegTolerance, 60);
    reg_write(RegMinBits, 4);
    reg_write(RegMinPulses, 2);
    // single duration, then extreme magnitudes
    push_dur(0, 1'b1);
    push_dur(65535, 1'b0); push_dur(-65536, 1'b0); push_dur(-65535, 1'b0); push_dur(1, 1'b1);
    // exact frame on the first table entry, code 1011
    push_dur(350, 1'b0);  push_dur(-10850, 1'b0);
    push_dur(1050, 1'b0); push_dur(-350, 1'b0);  push_dur(350, 1'b0);  push_dur(-1050, 1'b0);
    push_dur(1050, 1'b0); push_dur(-350, 1'b0);  push_dur(1050, 1'b0); push_dur(-350, 1'b0);
    // long sync entry with overlapping zero and one windows
    push_dur(26000, 1'b0); push_dur(-1400, 1'b0);
    push_dur(3200, 1'b0);  push_dur(-1400, 1'b0); push_dur(3200, 1'b0); push_dur(-600, 1'b0);
    push_dur(3200, 1'b0);  push_dur(-1400, 1'b0); push_dur(3200, 1'b0); push_dur(-1400, 1'b1);
    wait_drained();

    run_phase(60, 8, 20, 1'b1, 300, 1'b1, 1'b0);
    run_phase(0, 1, 2, 1'b0, 200, 1'b0, 1'b0);
    run_phase(50, 16, 512, 1'b1, 620, 1'b0, 1'b1);
    run_phase(127, 40, 2, 1'b1, 40, 1'b0, 1'b0);
    run_phase(35, 0, 0, 1'b1, 180, 1'b0, 1'b0);
    run_phase(100, 32, 1023, 1'b0, 60, 1'b0, 1'b0);

    if (err_cnt == 0) begin
      $display("tb_remote_pulse_code_decoder OK");
    end else begin
      $display("tb_remote_pulse_code_decoder NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rpcd_pkg.sv
hdl/rpcd_regs.sv
hdl/rpcd_ctrl.sv
hdl/rpcd_dp.sv
hdl/remote_pulse_code_decoder.sv
sim/tb_remote_pulse_code_decoder.sv
